// ----- hdl/tcdr_pkg.sv -----
// shared types, constants and helper functions for the triangle clip depth range block
package tcdr_pkg;

   // sizing
   localparam int POLY_DEPTH_DEF = 10;
   localparam int MIN_VERTS      = 3;
   localparam int CFG_REGS       = 8;
   localparam int CFG_DATA_W     = 64;
   localparam int CFG_ADDR_W     = 6;
   localparam int CFG_IDX_LSB    = 3;

   // arithmetic widths
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_W      = PROD_W - FRAC_BITS;
   localparam int T_SHIFT    = 29;
   localparam int T_W        = T_SHIFT + 1;
   localparam int T_BITS     = T_SHIFT;
   localparam int PROJ_BITS  = 48;
   localparam int DIV_LEN_W  = 6;
   localparam int DIV_LOW_W  = 48;
   localparam int DIV_DVS_W  = 32;

   // coordinate and row codes
   localparam logic [1:0] AX_X  = 2'd0;
   localparam logic [1:0] AX_Y  = 2'd1;
   localparam logic [1:0] AX_Z  = 2'd2;
   localparam logic [1:0] ROW_W = 2'd3;
   localparam logic [1:0] COL_T = 2'd3;

   // clip pass codes
   localparam logic [2:0] PASS_NEAR = 3'd0;
   localparam logic [2:0] PASS_ZFAR = 3'd1;
   localparam logic [2:0] PASS_XHI  = 3'd2;
   localparam logic [2:0] PASS_XLO  = 3'd3;
   localparam logic [2:0] PASS_YHI  = 3'd4;
   localparam logic [2:0] PASS_YLO  = 3'd5;

   typedef logic signed [31:0] coord_type;
   typedef coord_type [2:0] vtx_type;
   typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] cfg_type;

   localparam coord_type FX_ONE     = 32'sh0001_0000;
   localparam coord_type FX_NEG_ONE = -32'sh0001_0000;
   localparam coord_type COORD_MAX  = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN  = 32'sh8000_0000;
   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   // identity matrix
   localparam cfg_type CFG_RESET = {
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
      64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type a_z;
      coord_type b_x;
      coord_type b_y;
      coord_type b_z;
      coord_type c_x;
      coord_type c_y;
      coord_type c_z;
      coord_type near_depth;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type min_depth;
      coord_type max_depth;
   } rsp_type;

   // sequencer to shared unit
   typedef struct packed {
      logic signed [MUL_W-1:0] mul_a;
      logic signed [MUL_W-1:0] mul_b;
      logic                    div_go;
      logic [DIV_DVS_W-1:0]    div_rem0;
      logic [DIV_LOW_W-1:0]    div_low;
      logic [DIV_LEN_W-1:0]    div_len;
      logic [DIV_DVS_W-1:0]    div_dvs;
   } alu_req_type;

   // shared unit to sequencer
   typedef struct packed {
      logic signed [PROD_W-1:0] mul_p;
      logic [DIV_LOW_W-1:0]     div_q;
      logic                     div_done;
   } alu_rsp_type;

   function automatic coord_type sat32(input logic signed [63:0] v);
      if (v > SAT_HI) return COORD_MAX;
      if (v < SAT_LO) return COORD_MIN;
      return v[31:0];
   endfunction

   function automatic coord_type mat_elem(input cfg_type cfg, input logic [1:0] r,
                                          input logic [1:0] c);
      logic [CFG_DATA_W-1:0] word;
      word = cfg[{r, c[1]}];
      return c[0] ? word[63:32] : word[31:0];
   endfunction

   function automatic logic in_plane(input coord_type c, input coord_type v,
                                     input logic nearp);
      if (nearp || v > 0) return c <= v;
      return c >= v;
   endfunction

   function automatic logic [1:0] plane_axis(input logic [2:0] pass);
      unique case (pass) inside
         PASS_NEAR, PASS_ZFAR: return AX_Z;
         PASS_XHI, PASS_XLO:   return AX_X;
         default:              return AX_Y;
      endcase
   endfunction

   function automatic coord_type plane_val(input logic [2:0] pass, input coord_type near);
      unique case (pass) inside
         PASS_NEAR:                    return near;
         PASS_ZFAR, PASS_XHI, PASS_YHI: return FX_ONE;
         default:                      return FX_NEG_ONE;
      endcase
   endfunction

endpackage

// ----- hdl/tcdr_req_if.sv -----
// request channel interface: three vertices and the near depth
interface tcdr_req_if import tcdr_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tcdr_rsp_if.sv -----
// response channel interface: hit flag and depth range
interface tcdr_rsp_if import tcdr_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tcdr_alu.sv -----
// shared arithmetic unit: registered 33x33 multiplier and bit-serial divider
module tcdr_alu import tcdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic signed [PROD_W-1:0] mul_p_ff;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_LEN_W-1:0]     bit_ff, bit_in;
   logic [DIV_DVS_W-1:0]     rem_ff, rem_in;
   logic [DIV_LOW_W-1:0]     q_ff, q_in;
   logic [DIV_DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_LOW_W-1:0]     low_ff, low_in;
   logic [DIV_DVS_W:0]       trial;
   logic                     ge;

   // one restoring step per cycle
   always_comb begin
      trial   = {rem_ff, low_ff[bit_ff]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      if (req.div_go) begin
         busy_in = 1'b1;
         bit_in  = req.div_len - DIV_LEN_W'(1);
         rem_in  = req.div_rem0;
         q_in    = '0;
         dvs_in  = req.div_dvs;
         low_in  = req.div_low;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DVS_W'(trial - {1'b0, dvs_ff}) : trial[DIV_DVS_W-1:0];
         q_in   = {q_ff[DIV_LOW_W-2:0], ge};
         bit_in = bit_ff - DIV_LEN_W'(1);
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // divider control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_p_ff <= $signed(req.mul_a) * $signed(req.mul_b);
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      dvs_ff   <= dvs_in;
      low_ff   <= low_in;
   end

   assign rsp.mul_p    = mul_p_ff;
   assign rsp.div_q    = q_ff;
   assign rsp.div_done = done_ff;

endmodule

// ----- hdl/tcdr_seq.sv -----
// clip sequencer: polygon buffers, plane passes, projection and depth range
module tcdr_seq import tcdr_pkg::*; #(
   parameter int POLY_DEPTH = POLY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcdr_req_if.sink    req_bus,
   tcdr_rsp_if.source  rsp_bus,
   input  cfg_type     cfg,
   output alu_req_type alu_req,
   input  alu_rsp_type alu_rsp
);

   localparam int IDX_W = $clog2(POLY_DEPTH);
   localparam int CNT_W = $clog2(POLY_DEPTH + 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PSTART = 5'd1;
   localparam logic [4:0] S_SCAN   = 5'd2;
   localparam logic [4:0] S_ADV    = 5'd3;
   localparam logic [4:0] S_TDIV   = 5'd4;
   localparam logic [4:0] S_TWAIT  = 5'd5;
   localparam logic [4:0] S_XMUL   = 5'd6;
   localparam logic [4:0] S_XACC   = 5'd7;
   localparam logic [4:0] S_XPUSH  = 5'd8;
   localparam logic [4:0] S_PEND   = 5'd9;
   localparam logic [4:0] S_PLOAD  = 5'd10;
   localparam logic [4:0] S_PMUL   = 5'd11;
   localparam logic [4:0] S_PACC   = 5'd12;
   localparam logic [4:0] S_PDIV   = 5'd13;
   localparam logic [4:0] S_PWAIT  = 5'd14;
   localparam logic [4:0] S_PWB    = 5'd15;
   localparam logic [4:0] S_MIN    = 5'd16;
   localparam logic [4:0] S_OUT    = 5'd17;

   logic [4:0]              state_ff, state_in;
   logic [2:0]              pass_ff, pass_in;
   logic                    src_ff, src_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   vtx_type                 prev_ff, prev_in;
   logic                    prev_in_ff, prev_in_in;
   vtx_type                 cur_ff, cur_in;
   logic                    cur_in_ff, cur_in_in;
   logic [T_W-1:0]          t_ff, t_in;
   logic [1:0]              crd_ff, crd_in;
   logic [1:0]              rsel_ff, rsel_in;
   vtx_type                 cut_ff, cut_in;
   vtx_type                 proj_ff, proj_in;
   coord_type [3:0]         row_ff, row_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   coord_type               near_ff, near_in;
   coord_type               mn_ff, mn_in;
   coord_type               mx_ff, mx_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   vtx_type                 tri_ff [3];
   vtx_type                 poly_ff [2][POLY_DEPTH];

   logic                    wr_en;
   logic                    wr_bank;
   logic [IDX_W-1:0]        wr_idx;
   vtx_type                 wr_vtx;

   logic [IDX_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        last_idx;
   vtx_type                 rd_vtx;
   logic                    rd_in;
   logic [1:0]              axis;
   coord_type               pval;
   logic                    nearp;
   logic                    can_push;
   logic                    accept;
   logic signed [32:0]      x_da, x_nm;
   logic [31:0]             da_mag, nm_mag;
   logic signed [37:0]      x_sum;
   logic signed [ACC_W-1:0] macc;
   coord_type               prow, wrow;
   logic [31:0]             prow_mag, wrow_mag;
   logic [DIV_LOW_W:0]      q_ext;
   logic signed [DIV_LOW_W:0] q_sgn;
   vtx_type                 cut_w;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = state_ff == S_IDLE;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // plane of the current pass and the buffer read port
   always_comb begin
      axis     = plane_axis(pass_ff);
      pval     = plane_val(pass_ff, near_ff);
      nearp    = pass_ff == PASS_NEAR;
      last_idx = IDX_W'(n_ff - CNT_W'(1));
      rd_idx   = (state_ff == S_PSTART) ? last_idx : idx_ff;
      rd_vtx   = nearp ? tri_ff[rd_idx[1:0]] : poly_ff[src_ff][rd_idx];
      rd_in    = in_plane(rd_vtx[axis], pval, nearp);
      can_push = cnt_ff < CNT_W'(POLY_DEPTH);
   end

   // crossing and projection arithmetic around the shared unit
   always_comb begin
      x_da     = 33'(cur_ff[axis]) - 33'(prev_ff[axis]);
      x_nm     = 33'(pval) - 33'(prev_ff[axis]);
      da_mag   = x_da[32] ? 32'(-x_da) : x_da[31:0];
      nm_mag   = x_nm[32] ? 32'(-x_nm) : x_nm[31:0];
      x_sum    = 38'($signed(prev_ff[crd_ff]))
               + 38'($signed(alu_rsp.mul_p[PROD_W-1:T_SHIFT]));
      macc     = acc_ff + $signed(alu_rsp.mul_p[PROD_W-1:FRAC_BITS]);
      prow     = row_ff[rsel_ff];
      wrow     = row_ff[ROW_W];
      prow_mag = prow[31] ? 32'(-prow) : prow;
      wrow_mag = wrow[31] ? 32'(-wrow) : wrow;
      q_ext    = {1'b0, alu_rsp.div_q};
      q_sgn    = (prow[31] ^ wrow[31]) ? -$signed(q_ext) : $signed(q_ext);
      cut_w    = cut_ff;
      cut_w[axis] = pval;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      src_in       = src_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      prev_in_in   = prev_in_ff;
      cur_in       = cur_ff;
      cur_in_in    = cur_in_ff;
      t_in         = t_ff;
      crd_in       = crd_ff;
      rsel_in      = rsel_ff;
      cut_in       = cut_ff;
      proj_in      = proj_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      near_in      = near_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_bank      = ~src_ff;
      wr_idx       = IDX_W'(cnt_ff);
      wr_vtx       = cur_ff;

      alu_req.mul_a    = MUL_W'($signed(mat_elem(cfg, rsel_ff, crd_ff)));
      alu_req.mul_b    = MUL_W'($signed(cur_ff[crd_ff]));
      alu_req.div_go   = 1'b0;
      alu_req.div_rem0 = '0;
      alu_req.div_low  = {prow_mag, 16'h0};
      alu_req.div_len  = DIV_LEN_W'(PROJ_BITS);
      alu_req.div_dvs  = wrow_mag;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               near_in  = req_bus.data.near_depth;
               pass_in  = PASS_NEAR;
               src_in   = 1'b1;
               n_in     = CNT_W'(MIN_VERTS);
               cnt_in   = '0;
               state_in = S_PSTART;
            end
         end
         // previous vertex starts as the last one
         S_PSTART: begin
            prev_in    = rd_vtx;
            prev_in_in = rd_in;
            idx_in     = '0;
            cnt_in     = '0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            cur_in    = rd_vtx;
            cur_in_in = rd_in;
            state_in  = (rd_in != prev_in_ff) ? S_TDIV : S_ADV;
         end
         // keep the current vertex if inside, then move on
         S_ADV: begin
            if (cur_in_ff && can_push) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            prev_in    = cur_ff;
            prev_in_in = cur_in_ff;
            if (idx_ff == last_idx) begin
               state_in = S_PEND;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN;
            end
         end
         // crossing parameter: trivial cases settle without a divide
         S_TDIV: begin
            crd_in = AX_X;
            if (x_da == '0 || x_nm == '0 || x_da[32] != x_nm[32]) begin
               t_in     = '0;
               state_in = S_XMUL;
            end else if (nm_mag >= da_mag) begin
               t_in     = T_W'(1) << T_SHIFT;
               state_in = S_XMUL;
            end else begin
               alu_req.div_go   = 1'b1;
               alu_req.div_rem0 = nm_mag;
               alu_req.div_low  = '0;
               alu_req.div_len  = DIV_LEN_W'(T_BITS);
               alu_req.div_dvs  = da_mag;
               state_in         = S_TWAIT;
            end
         end
         S_TWAIT: begin
            if (alu_rsp.div_done) begin
               t_in     = {1'b0, alu_rsp.div_q[T_BITS-1:0]};
               state_in = S_XMUL;
            end
         end
         S_XMUL: begin
            alu_req.mul_a = 33'($signed(cur_ff[crd_ff])) - 33'($signed(prev_ff[crd_ff]));
            alu_req.mul_b = MUL_W'(t_ff);
            state_in      = S_XACC;
         end
         S_XACC: begin
            cut_in[crd_ff] = sat32(64'(x_sum));
            if (crd_ff == AX_Z) begin
               state_in = S_XPUSH;
            end else begin
               crd_in   = crd_ff + 2'd1;
               state_in = S_XMUL;
            end
         end
         // crossing vertex, snapped onto the plane
         S_XPUSH: begin
            wr_vtx = cut_w;
            if (can_push) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = S_ADV;
         end
         S_PEND: begin
            n_in   = cnt_ff;
            src_in = ~src_ff;
            idx_in = '0;
            if (cnt_ff < CNT_W'(MIN_VERTS)) begin
               hit_in   = 1'b0;
               mn_in    = '0;
               mx_in    = '0;
               state_in = S_OUT;
            end else if (pass_ff == PASS_NEAR) begin
               pass_in  = PASS_ZFAR;
               state_in = S_PLOAD;
            end else if (pass_ff == PASS_YLO) begin
               state_in = S_MIN;
            end else begin
               pass_in  = pass_ff + 3'd1;
               state_in = S_PSTART;
            end
         end
         // projection: four row sums, then three divides by w
         S_PLOAD: begin
            cur_in   = rd_vtx;
            rsel_in  = AX_X;
            crd_in   = AX_X;
            acc_in   = ACC_W'($signed(mat_elem(cfg, AX_X, COL_T)));
            state_in = S_PMUL;
         end
         S_PMUL: begin
            state_in = S_PACC;
         end
         S_PACC: begin
            acc_in = macc;
            if (crd_ff == AX_Z) begin
               row_in[rsel_ff] = sat32(64'(macc));
               crd_in          = AX_X;
               if (rsel_ff == ROW_W) begin
                  rsel_in  = AX_X;
                  state_in = S_PDIV;
               end else begin
                  rsel_in  = rsel_ff + 2'd1;
                  acc_in   = ACC_W'($signed(mat_elem(cfg, rsel_ff + 2'd1, COL_T)));
                  state_in = S_PMUL;
               end
            end else begin
               crd_in   = crd_ff + 2'd1;
               state_in = S_PMUL;
            end
         end
         S_PDIV: begin
            if (wrow == '0) begin
               proj_in[rsel_ff] = (prow > 0) ? COORD_MAX : ((prow < 0) ? COORD_MIN : '0);
               if (rsel_ff == AX_Z) begin
                  state_in = S_PWB;
               end else begin
                  rsel_in = rsel_ff + 2'd1;
               end
            end else begin
               alu_req.div_go = 1'b1;
               state_in       = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (alu_rsp.div_done) begin
               proj_in[rsel_ff] = sat32(64'(q_sgn));
               if (rsel_ff == AX_Z) begin
                  state_in = S_PWB;
               end else begin
                  rsel_in  = rsel_ff + 2'd1;
                  state_in = S_PDIV;
               end
            end
         end
         S_PWB: begin
            wr_en   = 1'b1;
            wr_bank = src_ff;
            wr_idx  = idx_ff;
            wr_vtx  = proj_ff;
            if (idx_ff == last_idx) begin
               state_in = S_PSTART;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_PLOAD;
            end
         end
         // depth range over the surviving polygon
         S_MIN: begin
            if (idx_ff == '0) begin
               mn_in = rd_vtx[AX_Z];
               mx_in = rd_vtx[AX_Z];
            end else begin
               if (rd_vtx[AX_Z] < mn_ff) mn_in = rd_vtx[AX_Z];
               if (rd_vtx[AX_Z] > mx_ff) mx_in = rd_vtx[AX_Z];
            end
            if (idx_ff == last_idx) begin
               hit_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.hit       = hit_ff;
               rsp_data_in.min_depth = mn_ff;
               rsp_data_in.max_depth = mx_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      src_ff      <= src_in;
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      prev_in_ff  <= prev_in_in;
      cur_ff      <= cur_in;
      cur_in_ff   <= cur_in_in;
      t_ff        <= t_in;
      crd_ff      <= crd_in;
      rsel_ff     <= rsel_in;
      cut_ff      <= cut_in;
      proj_ff     <= proj_in;
      row_ff      <= row_in;
      acc_ff      <= acc_in;
      near_ff     <= near_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // input triangle and polygon buffers
   always_ff @(posedge clock) begin
      if (accept) begin
         tri_ff[0] <= {req_bus.data.a_z, req_bus.data.a_y, req_bus.data.a_x};
         tri_ff[1] <= {req_bus.data.b_z, req_bus.data.b_y, req_bus.data.b_x};
         tri_ff[2] <= {req_bus.data.c_z, req_bus.data.c_y, req_bus.data.c_x};
      end
      if (wr_en) begin
         poly_ff[wr_bank][wr_idx] <= wr_vtx;
      end
   end

   // a new triangle always starts with a pass setup
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_PSTART)
      else $error("accepted beat did not start a clip pass");

   // vertex count never exceeds the buffer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> n_ff <= CNT_W'(POLY_DEPTH) && cnt_ff <= CNT_W'(POLY_DEPTH))
      else $error("polygon count beyond buffer depth");

   // divider finishes only while a divide is awaited
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.div_done |-> (state_ff == S_TWAIT || state_ff == S_PWAIT))
      else $error("divide result with no waiting state");

   // a reported hit carries an ordered depth range
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit |-> rsp_data_ff.min_depth <= rsp_data_ff.max_depth)
      else $error("min depth above max depth");

endmodule

// ----- hdl/triangle_clip_depth_range_top.sv -----
// Triangle clip and depth range top level. One beat on req_bus carries a view-space
// triangle and a near depth; the block clips it against the near plane, projects the
// survivors through the 4x4 matrix held in the eight 64-bit registers (APB, register i at
// byte 8*i), clips against the far plane z = 1 and the four side planes of the unit cube
// and returns one beat on rsp_bus with the hit flag and the least and greatest projected z.
// One shared arithmetic unit does all the math: its divider yields one quotient bit a
// cycle (48 bits per projected coordinate, 29 per crossing) and its multiplier serves every
// row sum and interpolation. req_bus.ready is low while a triangle is in flight; a finished
// result waits in an output register so the next triangle can be taken before it is read.
module triangle_clip_depth_range_top import tcdr_pkg::*; #(
   parameter int POLY_DEPTH = POLY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tcdr_req_if.sink              req_bus,
   tcdr_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [CFG_DATA_W-1:0] pwdata,
   output logic [CFG_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type     cfg_ff;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic [2:0]  csr_idx;

   assign csr_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
   assign pready  = 1'b1;
   assign prdata  = cfg_ff[csr_idx];

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (psel && penable && pwrite) begin
         cfg_ff[csr_idx] <= pwdata;
      end
   end

   tcdr_seq #(
      .POLY_DEPTH (POLY_DEPTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cfg     (cfg_ff),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   tcdr_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

endmodule

// ----- verif/triangle_clip_depth_range_checker.sv -----
// checker for the triangle clip depth range block: predicts each result and compares it
module triangle_clip_depth_range_checker import tcdr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tcdr_req_if                   req_mon,
   tcdr_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [CFG_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int PD = POLY_DEPTH_DEF;
   localparam longint Q_ONE = 65536;
   localparam longint T_ONE = longint'(1) << T_SHIFT;

   typedef longint poly_type [PD][3];
   typedef longint pt_type [3];

   cfg_type   matrix_shadow;
   rsp_type   depth_queue [$];

   function automatic longint clamp32(input longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic longint coef(input int r, input int c);
      logic [63:0] word;
      word = matrix_shadow[r * 2 + c / 2];
      return (c % 2) ? longint'($signed(word[63:32])) : longint'($signed(word[31:0]));
   endfunction

   // row sums with floored products, then divide by w
   function automatic void to_clip_space(input pt_type v, output pt_type o);
      longint row [4];
      longint acc;
      for (int r = 0; r < 4; r++) begin
         acc = coef(r, 3);
         for (int c = 0; c < 3; c++) acc += (coef(r, c) * v[c]) >>> 16;
         row[r] = clamp32(acc);
      end
      for (int r = 0; r < 3; r++) begin
         if (row[3] == 0) o[r] = row[r] > 0 ? 64'sh7FFF_FFFF :
                                 (row[r] < 0 ? -64'sh8000_0000 : 0);
         else o[r] = clamp32((row[r] * Q_ONE) / row[3]);
      end
   endfunction

   function automatic bit on_keep_side(input pt_type v, input int ax, input longint val,
                                       input bit nearp);
      if (nearp || val > 0) return v[ax] <= val;
      return v[ax] >= val;
   endfunction

   // one sutherland-hodgman pass against a single plane
   function automatic int clip_plane(input poly_type src, input int n, output poly_type dst,
                                     input int ax, input longint val, input bit nearp);
      int cnt;
      pt_type prv, cur, cut;
      bit prv_in, cur_in;
      longint da, t;
      cnt = 0;
      if (n <= 0) return 0;
      prv = src[n - 1];
      prv_in = on_keep_side(prv, ax, val, nearp);
      for (int i = 0; i < n; i++) begin
         cur = src[i];
         cur_in = on_keep_side(cur, ax, val, nearp);
         if (cur_in != prv_in) begin
            da = cur[ax] - prv[ax];
            t = 0;
            if (da != 0) t = ((val - prv[ax]) * T_ONE) / da;
            if (t < 0) t = 0;
            if (t > T_ONE) t = T_ONE;
            for (int c = 0; c < 3; c++)
               cut[c] = clamp32(prv[c] + (((cur[c] - prv[c]) * t) >>> T_SHIFT));
            cut[ax] = val;
            if (cnt < PD) begin
               dst[cnt] = cut;
               cnt++;
            end
         end
         if (cur_in && cnt < PD) begin
            dst[cnt] = cur;
            cnt++;
         end
         prv = cur;
         prv_in = cur_in;
      end
      return cnt;
   endfunction

   function automatic rsp_type predict_depth_range(input req_type r);
      rsp_type res;
      poly_type pa, pb;
      pt_type tmp;
      int n;
      longint mn, mx;
      res = '0;
      pa[0] = '{longint'(r.a_x), longint'(r.a_y), longint'(r.a_z)};
      pa[1] = '{longint'(r.b_x), longint'(r.b_y), longint'(r.b_z)};
      pa[2] = '{longint'(r.c_x), longint'(r.c_y), longint'(r.c_z)};
      n = clip_plane(pa, 3, pb, 2, longint'(r.near_depth), 1'b1);
      if (n < 3) return res;
      for (int i = 0; i < n; i++) begin
         to_clip_space(pb[i], tmp);
         pb[i] = tmp;
      end
      n = clip_plane(pb, n, pa, 2, Q_ONE, 1'b0);
      if (n < 3) return res;
      n = clip_plane(pa, n, pb, 0, Q_ONE, 1'b0);
      if (n < 3) return res;
      n = clip_plane(pb, n, pa, 0, -Q_ONE, 1'b0);
      if (n < 3) return res;
      n = clip_plane(pa, n, pb, 1, Q_ONE, 1'b0);
      if (n < 3) return res;
      n = clip_plane(pb, n, pa, 1, -Q_ONE, 1'b0);
      if (n < 3) return res;
      mn = pa[0][2];
      mx = pa[0][2];
      for (int i = 1; i < n; i++) begin
         if (pa[i][2] < mn) mn = pa[i][2];
         if (pa[i][2] > mx) mx = pa[i][2];
      end
      res.hit = 1'b1;
      res.min_depth = mn[31:0];
      res.max_depth = mx[31:0];
      return res;
   endfunction

   assign pending_count = depth_queue.size();

   // register shadow, prediction on request beats, compare on result beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         matrix_shadow <= CFG_RESET;
         depth_queue.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready)
            matrix_shadow[paddr[CFG_ADDR_W-1:CFG_IDX_LSB]] <= pwdata;
         if (req_mon.valid && req_mon.ready)
            depth_queue.push_back(predict_depth_range(req_mon.data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (depth_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat hit=%0b min=%0d max=%0d",
                           rsp_mon.data.hit, rsp_mon.data.min_depth,
                           rsp_mon.data.max_depth);
               fail_count <= fail_count + 1;
            end else begin
               want = depth_queue.pop_front();
               if (rsp_mon.data.hit !== want.hit ||
                   rsp_mon.data.min_depth !== want.min_depth ||
                   rsp_mon.data.max_depth !== want.max_depth) begin
                  if (fail_count < 10)
                     $display("expected hit=%0b min=%0d max=%0d got hit=%0b min=%0d max=%0d",
                              want.hit, want.min_depth, want.max_depth, rsp_mon.data.hit,
                              rsp_mon.data.min_depth, rsp_mon.data.max_depth);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- verif/triangle_clip_depth_range_top_tb.sv -----
// stimulus and verdict for the triangle clip depth range block
module triangle_clip_depth_range_top_tb import tcdr_pkg::*; ();

   localparam int PHASE_ITEMS = 300;
   localparam longint CYCLE_LIMIT = 20000000;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CFG_ADDR_W-1:0] paddr;
   logic [CFG_DATA_W-1:0] pwdata;
   logic [CFG_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count, pending_count;
   bit                    idle_on;
   longint                cycles = 0;
   logic [63:0]           mtx [8];

   tcdr_req_if req_bus ();
   tcdr_rsp_if rsp_bus ();

   triangle_clip_depth_range_top u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   triangle_clip_depth_range_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready = idle_on ? ($urandom_range(99) >= 8) : 1'b1;
   end

   task automatic csr_write(input int idx, input logic [63:0] val);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = CFG_ADDR_W'(idx << CFG_IDX_LSB);
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // wait for the block to drain, then load all eight matrix words
   task automatic load_matrix();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      for (int i = 0; i < 8; i++) csr_write(i, mtx[i]);
   endtask

   task automatic send_tri(input req_type t);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 8) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data = t;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic coord_type pick_coord(input int mode);
      int k;
      if (mode < 60) return coord_type'($urandom_range(393216) - 196608);
      if (mode < 75) begin
         k = $urandom_range(4);
         case (k)
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return FX_ONE;
            3: return FX_NEG_ONE;
            default: return '0;
         endcase
      end
      return coord_type'($urandom);
   endfunction

   function automatic req_type random_tri();
      req_type t;
      int mode;
      mode = $urandom_range(99);
      t.a_x = pick_coord(mode);
      t.a_y = pick_coord(mode);
      t.a_z = pick_coord(mode);
      t.b_x = pick_coord(mode);
      t.b_y = pick_coord(mode);
      t.b_z = pick_coord(mode);
      t.c_x = pick_coord(mode);
      t.c_y = pick_coord(mode);
      t.c_z = pick_coord(mode);
      t.near_depth = pick_coord($urandom_range(99));
      return t;
   endfunction

   function automatic req_type make_tri(input coord_type ax, ay, az, bx, by, bz,
                                        cx, cy, cz, nd);
      req_type t;
      t = '{ax, ay, az, bx, by, bz, cx, cy, cz, nd};
      return t;
   endfunction

   function automatic logic [63:0] pair(input coord_type lo, input coord_type hi);
      return {hi, lo};
   endfunction

   initial begin
      req_type t;
      coord_type h;
      idle_on = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed triangles with the reset identity matrix
      h = 32'sh0000_8000;
      send_tri(make_tri(-h, -h, 0, h, -h, 0, 0, h, 0, FX_ONE));
      send_tri(make_tri(-h, -h, -h, h, -h, h, 0, h, 0, 0));
      send_tri(make_tri(3 * FX_ONE, 0, 0, 4 * FX_ONE, 0, 0, 3 * FX_ONE, h, 0, FX_ONE));
      send_tri(make_tri(-3 * FX_ONE, -h, 0, 3 * FX_ONE, -h, 0, 0, 3 * FX_ONE, 0, FX_ONE));
      send_tri(make_tri(-h, -h, 2 * FX_ONE, h, -h, -h, 0, h, 0, FX_ONE));
      send_tri(make_tri(h, h, 0, h, h, 0, h, h, 0, FX_ONE));
      send_tri(make_tri(-h, 0, 0, h, 0, 0, 0, 0, 0, FX_ONE));
      send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, COORD_MIN));
      send_tri(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_tri(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_tri(make_tri(COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX,
                        COORD_MIN, COORD_MAX));
      send_tri(make_tri(-4 * FX_ONE, -4 * FX_ONE, 0, 4 * FX_ONE, -4 * FX_ONE, 0,
                        0, 4 * FX_ONE, 0, FX_ONE));
      send_tri(make_tri(-h, -h, 0, h, -h, 0, 0, h, 0, 0));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            // perspective with w = -z
            1: begin
               mtx = '{pair(FX_ONE, 0), 0, pair(0, FX_ONE), 0, 0, pair(FX_ONE, 0),
                       0, pair(FX_NEG_ONE, 0)};
               load_matrix();
            end
            // small random matrix, no idling at all
            2: begin
               for (int i = 0; i < 8; i++)
                  mtx[i] = pair(coord_type'($urandom_range(262144) - 131072),
                                coord_type'($urandom_range(262144) - 131072));
               mtx[7] = pair(coord_type'($urandom_range(65536) - 32768),
                             coord_type'($urandom_range(131072) + 32768));
               idle_on = 1'b0;
               load_matrix();
            end
            // full random words
            3: begin
               idle_on = 1'b1;
               for (int i = 0; i < 8; i++) mtx[i] = {$urandom, $urandom};
               load_matrix();
            end
            // zero matrix apart from the x coefficient of row 0: w is zero everywhere
            4: begin
               for (int i = 0; i < 8; i++) mtx[i] = '0;
               mtx[0] = pair(FX_ONE, 0);
               load_matrix();
            end
            // all ones, then back to identity halfway
            5: begin
               for (int i = 0; i < 8; i++) mtx[i] = '1;
               load_matrix();
            end
            default: ;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == PHASE_ITEMS / 2)
               while (pending_count != 0) @(posedge clock);
            if (phase == 5 && n == PHASE_ITEMS / 2) begin
               mtx = '{pair(FX_ONE, 0), 0, pair(0, FX_ONE), 0, 0, pair(FX_ONE, 0),
                       0, pair(0, FX_ONE)};
               load_matrix();
            end
            send_tri(random_tri());
         end
      end

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
